FILE: rtl/core/cmpt_pkg.sv
// Shared types and constants for the compare timer with millisecond tick.
// Used by cmpt_cfg, cmpt_core and compare_timer_with_ms_tick; no dependencies.
package cmpt_pkg;

	localparam int NUM_CH    = 4;
	localparam int CH_W      = 3;
	localparam int CNT_W     = 16;
	localparam int MS_W      = 32;
	localparam int DIV_W     = 7;
	localparam int PRE_W     = 6;
	localparam int FLAG_W    = 4;
	localparam int ADDR_W    = 3;
	localparam int DATA_W    = 32;

	localparam logic [DIV_W-1:0] DIV_RESET = 7'd64;
	localparam logic [DIV_W-1:0] DIV_MAX   = 7'd64;
	localparam logic [CNT_W-1:0] MS_RESET  = 16'd125;

	// channel roles, zero based
	localparam int CH_PERIODIC = 2;
	localparam int CH_LATCH    = 3;

	// event flag bit positions
	localparam int FLAG_CH1 = 0;
	localparam int FLAG_CH2 = 1;
	localparam int FLAG_CH4 = 2;
	localparam int FLAG_OVF = 3;

	// register index, taken from paddr[2]
	localparam logic REG_DIVIDER = 1'b0;
	localparam logic REG_PERIOD  = 1'b1;

	typedef enum logic [1:0] {
		MODE_TICK  = 2'd0,
		MODE_ARM   = 2'd1,
		MODE_CLEAR = 2'd2,
		MODE_READ  = 2'd3
	} mode_t;

	typedef struct packed {
		logic [DIV_W-1:0] divider;
		logic [CNT_W-1:0] period;
	} cfg_t;

	typedef struct packed {
		logic [FLAG_W-1:0] flags;
		logic [MS_W-1:0]   ms_count;
		logic [CNT_W-1:0]  ovf_count;
		logic [CNT_W-1:0]  counter;
		logic              wake;
	} rsp_t;

endpackage

FILE: rtl/core/cmpt_cfg.sv
// APB-style configuration registers: prescale divider and millisecond period.
// Depends on cmpt_pkg.
module cmpt_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [cmpt_pkg::ADDR_W-1:0]  paddr,
	input  logic [cmpt_pkg::DATA_W-1:0]  pwdata,
	output logic [cmpt_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	output cmpt_pkg::cfg_t               cfg
);

	logic [cmpt_pkg::DIV_W-1:0] divider_q;
	logic [cmpt_pkg::CNT_W-1:0] period_q;
	logic                       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			divider_q <= cmpt_pkg::DIV_RESET;
			period_q  <= cmpt_pkg::MS_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				cmpt_pkg::REG_DIVIDER: divider_q <= pwdata[cmpt_pkg::DIV_W-1:0];
				cmpt_pkg::REG_PERIOD:  period_q  <= pwdata[cmpt_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			cmpt_pkg::REG_DIVIDER:
				prdata = {{(cmpt_pkg::DATA_W-cmpt_pkg::DIV_W){1'b0}}, divider_q};
			cmpt_pkg::REG_PERIOD:
				prdata = {{(cmpt_pkg::DATA_W-cmpt_pkg::CNT_W){1'b0}}, period_q};
			default:
				prdata = '0;
		endcase
	end

	assign cfg.divider = divider_q;
	assign cfg.period  = period_q;

endmodule

FILE: rtl/core/cmpt_core.sv
// Timer state and single-pass request logic: prescaler, counter, compare
// channels, flags and counts. Depends on cmpt_pkg.
module cmpt_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fire,
	input  logic [1:0]                  mode,
	input  logic [cmpt_pkg::CH_W-1:0]   channel,
	input  logic [cmpt_pkg::CNT_W-1:0]  delay_ticks,
	input  cmpt_pkg::cfg_t              cfg,
	output cmpt_pkg::rsp_t              rsp
);

	logic [cmpt_pkg::PRE_W-1:0]  pre_q,   pre_d;
	logic [cmpt_pkg::CNT_W-1:0]  timer_q, timer_d;
	logic [cmpt_pkg::CNT_W-1:0]  cmp_q [cmpt_pkg::NUM_CH];
	logic [cmpt_pkg::CNT_W-1:0]  cmp_d [cmpt_pkg::NUM_CH];
	logic [cmpt_pkg::NUM_CH-1:0] en_q,    en_d;
	logic [cmpt_pkg::FLAG_W-1:0] flags_q, flags_d;
	logic [cmpt_pkg::MS_W-1:0]   ms_q,    ms_d;
	logic [cmpt_pkg::CNT_W-1:0]  ovf_q,   ovf_d;
	logic                        wake_d;

	logic [cmpt_pkg::DIV_W-1:0]  div_eff;
	logic [cmpt_pkg::DIV_W-1:0]  pre_inc;
	logic [cmpt_pkg::CNT_W-1:0]  timer_inc;

	// divider of zero acts as one, above max saturates
	always_comb begin
		if (cfg.divider == '0)
			div_eff = 7'd1;
		else if (cfg.divider > cmpt_pkg::DIV_MAX)
			div_eff = cmpt_pkg::DIV_MAX;
		else
			div_eff = cfg.divider;
	end

	assign pre_inc   = {1'b0, pre_q} + 7'd1;
	assign timer_inc = timer_q + 16'd1;

	always_comb begin
		pre_d   = pre_q;
		timer_d = timer_q;
		en_d    = en_q;
		flags_d = flags_q;
		ms_d    = ms_q;
		ovf_d   = ovf_q;
		wake_d  = 1'b0;
		for (int k = 0; k < cmpt_pkg::NUM_CH; k++)
			cmp_d[k] = cmp_q[k];

		unique case (cmpt_pkg::mode_t'(mode))
			cmpt_pkg::MODE_TICK: begin
				if (pre_inc >= div_eff) begin
					pre_d   = '0;
					timer_d = timer_inc;
					if (timer_inc == '0) begin
						ovf_d                       = ovf_q + 16'd1;
						flags_d[cmpt_pkg::FLAG_OVF] = 1'b1;
						wake_d                      = 1'b1;
					end
					for (int k = 0; k < cmpt_pkg::NUM_CH; k++) begin
						if (en_q[k] && cmp_q[k] == timer_inc) begin
							if (k == cmpt_pkg::CH_PERIODIC) begin
								cmp_d[k] = cmp_q[k] + cfg.period;
								ms_d     = ms_q + 32'd1;
								wake_d   = 1'b1;
							end else if (k == cmpt_pkg::CH_LATCH) begin
								flags_d[cmpt_pkg::FLAG_CH4] = 1'b1;
							end else begin
								en_d[k] = 1'b0;
								if (k == 0) begin
									flags_d[cmpt_pkg::FLAG_CH1] = 1'b1;
									wake_d                      = 1'b1;
								end else if (k == 1) begin
									flags_d[cmpt_pkg::FLAG_CH2] = 1'b1;
									wake_d                      = 1'b1;
								end
							end
						end
					end
				end else begin
					pre_d = pre_inc[cmpt_pkg::PRE_W-1:0];
				end
			end
			cmpt_pkg::MODE_ARM: begin
				for (int k = 0; k < cmpt_pkg::NUM_CH; k++) begin
					if (channel == cmpt_pkg::CH_W'(k + 1)) begin
						cmp_d[k] = timer_q + delay_ticks;
						en_d[k]  = 1'b1;
						if (k == cmpt_pkg::CH_LATCH)
							flags_d[cmpt_pkg::FLAG_CH4] = 1'b0;
					end
				end
			end
			cmpt_pkg::MODE_CLEAR: begin
				flags_d = '0;
			end
			cmpt_pkg::MODE_READ: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_q   <= '0;
			timer_q <= '0;
			en_q    <= '0;
			flags_q <= '0;
			ms_q    <= '0;
			ovf_q   <= '0;
			for (int k = 0; k < cmpt_pkg::NUM_CH; k++)
				cmp_q[k] <= '0;
		end else if (fire) begin
			pre_q   <= pre_d;
			timer_q <= timer_d;
			en_q    <= en_d;
			flags_q <= flags_d;
			ms_q    <= ms_d;
			ovf_q   <= ovf_d;
			for (int k = 0; k < cmpt_pkg::NUM_CH; k++)
				cmp_q[k] <= cmp_d[k];
		end
	end

	// response reflects state after this request
	assign rsp.flags     = flags_d;
	assign rsp.ms_count  = ms_d;
	assign rsp.ovf_count = ovf_d;
	assign rsp.counter   = timer_d;
	assign rsp.wake      = wake_d;

endmodule

FILE: rtl/core/compare_timer_with_ms_tick.sv
// Compare timer with millisecond tick: request register, core logic, response register.
// Depends on cmpt_pkg, cmpt_cfg and cmpt_core.
// A request waits in stage 1; its result enters the response register when it fires.
// One request per cycle unless responses stall; the core's timer state feeds back on itself.
// Reset: arst_n clears the counter, prescaler, compares, enables, flags and counts,
// and loads divider 64 and period 125; no clearing pass is needed.
module compare_timer_with_ms_tick (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [cmpt_pkg::ADDR_W-1:0]  paddr,
	input  logic [cmpt_pkg::DATA_W-1:0]  pwdata,
	output logic [cmpt_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	// request channel
	input  logic                         req_valid,
	output logic                         req_stall,
	input  logic [1:0]                   mode,
	input  logic [cmpt_pkg::CH_W-1:0]    channel,
	input  logic [cmpt_pkg::CNT_W-1:0]   delay_ticks,
	// response channel
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output logic [cmpt_pkg::FLAG_W-1:0]  event_flags,
	output logic [cmpt_pkg::MS_W-1:0]    millisecond_count,
	output logic [cmpt_pkg::CNT_W-1:0]   overflow_count,
	output logic [cmpt_pkg::CNT_W-1:0]   counter_value,
	output logic                         wake
);

	cmpt_pkg::cfg_t cfg;
	cmpt_pkg::rsp_t rsp_d;
	cmpt_pkg::rsp_t rsp_q;

	// request stage
	logic                        valid_s1;
	logic [1:0]                  mode_s1;
	logic [cmpt_pkg::CH_W-1:0]   chan_s1;
	logic [cmpt_pkg::CNT_W-1:0]  delay_s1;

	logic rsp_valid_q;
	logic advance;   // response register can take a new result
	logic fire;      // request in stage 1 is executed this cycle

	cmpt_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The response register is empty or being drained: stage 1 moves on.
	// Stage 1 then is free to take a new request in the same cycle, so a
	// full response register never blocks intake unless it is stalled.
	assign advance   = !rsp_valid_q || !rsp_stall;
	assign fire      = valid_s1 && advance;
	assign req_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!req_stall)
			valid_s1 <= req_valid;
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			mode_s1  <= mode;
			chan_s1  <= channel;
			delay_s1 <= delay_ticks;
		end
	end

	// Core updates the timer state at the edge the request fires and hands
	// back the post-request view of that state in the same cycle.
	cmpt_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.mode        (mode_s1),
		.channel     (chan_s1),
		.delay_ticks (delay_s1),
		.cfg         (cfg),
		.rsp         (rsp_d)
	);

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (advance)
			rsp_valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (fire)
			rsp_q <= rsp_d;
	end

	assign rsp_valid         = rsp_valid_q;
	assign event_flags       = rsp_q.flags;
	assign millisecond_count = rsp_q.ms_count;
	assign overflow_count    = rsp_q.ovf_count;
	assign counter_value     = rsp_q.counter;
	assign wake              = rsp_q.wake;

endmodule

FILE: test/cmpt_status_checker.sv
// Response checker for compare_timer_with_ms_tick: predicts each status response
// from the accepted requests and register writes, and compares it with the DUT.
// Depends on cmpt_pkg.
module cmpt_status_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic                         pready,
	input  logic [cmpt_pkg::ADDR_W-1:0]  paddr,
	input  logic [cmpt_pkg::DATA_W-1:0]  pwdata,
	input  logic                         req_valid,
	input  logic                         req_stall,
	input  logic [1:0]                   mode,
	input  logic [cmpt_pkg::CH_W-1:0]    channel,
	input  logic [cmpt_pkg::CNT_W-1:0]   delay_ticks,
	input  logic                         rsp_valid,
	input  logic                         rsp_stall,
	input  logic [cmpt_pkg::FLAG_W-1:0]  event_flags,
	input  logic [cmpt_pkg::MS_W-1:0]    millisecond_count,
	input  logic [cmpt_pkg::CNT_W-1:0]   overflow_count,
	input  logic [cmpt_pkg::CNT_W-1:0]   counter_value,
	input  logic                         wake,
	output int                           fail_count,
	output int                           pending,
	output int                           checked,
	output int                           wakes_seen,
	output int                           wraps_predicted
);

	// shadow registers and timer state
	logic [cmpt_pkg::DIV_W-1:0]  div_reg;
	logic [cmpt_pkg::CNT_W-1:0]  period_reg;
	logic [cmpt_pkg::PRE_W-1:0]  pre_cnt;
	logic [cmpt_pkg::CNT_W-1:0]  tcount;
	logic [cmpt_pkg::CNT_W-1:0]  cmp [cmpt_pkg::NUM_CH];
	logic [cmpt_pkg::NUM_CH-1:0] armed;
	logic [cmpt_pkg::FLAG_W-1:0] flags;
	logic [cmpt_pkg::MS_W-1:0]   ms_ticks;
	logic [cmpt_pkg::CNT_W-1:0]  wraps;

	cmpt_pkg::rsp_t expected_status [$];
	int   mismatches;
	int   n_checked;
	int   n_wakes;

	task automatic count_up(output bit woke);
		woke = 1'b0;
		tcount = tcount + 1'b1;
		if (tcount == '0) begin
			wraps = wraps + 1'b1;
			flags[cmpt_pkg::FLAG_OVF] = 1'b1;
			woke = 1'b1;
		end
		for (int k = 0; k < cmpt_pkg::NUM_CH; k++) begin
			if (armed[k] && cmp[k] == tcount) begin
				if (k == cmpt_pkg::CH_PERIODIC) begin
					cmp[k] = cmp[k] + period_reg;
					ms_ticks = ms_ticks + 1'b1;
					woke = 1'b1;
				end else if (k == cmpt_pkg::CH_LATCH) begin
					flags[cmpt_pkg::FLAG_CH4] = 1'b1;
				end else begin
					// one-shot channels drop their enable on the match
					armed[k] = 1'b0;
					flags[(k == 0) ? cmpt_pkg::FLAG_CH1 : cmpt_pkg::FLAG_CH2] = 1'b1;
					woke = 1'b1;
				end
			end
		end
	endtask

	task automatic predict_status(input cmpt_pkg::mode_t m,
			input logic [cmpt_pkg::CH_W-1:0] ch, input logic [cmpt_pkg::CNT_W-1:0] d);
		cmpt_pkg::rsp_t want;
		bit   woke;
		int   eff_div;
		woke = 1'b0;
		case (m)
			cmpt_pkg::MODE_TICK: begin
				eff_div = int'(div_reg);
				if (eff_div == 0)
					eff_div = 1;
				if (eff_div > int'(cmpt_pkg::DIV_MAX))
					eff_div = int'(cmpt_pkg::DIV_MAX);
				if (pre_cnt + 1 >= eff_div) begin
					pre_cnt = '0;
					count_up(woke);
				end else begin
					pre_cnt = pre_cnt + 1'b1;
				end
			end
			cmpt_pkg::MODE_ARM: begin
				// channel 0 and channels past the last one are ignored
				if (ch >= 1 && ch <= cmpt_pkg::NUM_CH) begin
					cmp[ch-1] = tcount + d;
					armed[ch-1] = 1'b1;
					if (ch - 1 == cmpt_pkg::CH_LATCH)
						flags[cmpt_pkg::FLAG_CH4] = 1'b0;
				end
			end
			cmpt_pkg::MODE_CLEAR: begin
				flags = '0;
			end
			default: begin
			end
		endcase
		want.flags     = flags;
		want.ms_count  = ms_ticks;
		want.ovf_count = wraps;
		want.counter   = tcount;
		want.wake      = woke;
		expected_status.push_back(want);
	endtask

	task automatic check_status();
		cmpt_pkg::rsp_t got;
		cmpt_pkg::rsp_t want;
		got.flags     = event_flags;
		got.ms_count  = millisecond_count;
		got.ovf_count = overflow_count;
		got.counter   = counter_value;
		got.wake      = wake;
		n_checked++;
		if (wake === 1'b1)
			n_wakes++;
		if (expected_status.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("response with no request outstanding: flags %h count %h",
					got.flags, got.counter);
		end else begin
			want = expected_status.pop_front();
			if (got.flags !== want.flags || got.ms_count !== want.ms_count ||
					got.ovf_count !== want.ovf_count || got.counter !== want.counter ||
					got.wake !== want.wake) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("response %0d mismatch: expected flags %h ms %0d ovf %0d cnt %h wake %b",
						n_checked, want.flags, want.ms_count, want.ovf_count,
						want.counter, want.wake);
					$display("  got flags %h ms %0d ovf %0d cnt %h wake %b",
						got.flags, got.ms_count, got.ovf_count, got.counter, got.wake);
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_reg    = cmpt_pkg::DIV_RESET;
			period_reg = cmpt_pkg::MS_RESET;
			pre_cnt    = '0;
			tcount     = '0;
			for (int k = 0; k < cmpt_pkg::NUM_CH; k++)
				cmp[k] = '0;
			armed      = '0;
			flags      = '0;
			ms_ticks   = '0;
			wraps      = '0;
			mismatches = 0;
			n_checked  = 0;
			n_wakes    = 0;
			expected_status.delete();
			fail_count      <= 0;
			pending         <= 0;
			checked         <= 0;
			wakes_seen      <= 0;
			wraps_predicted <= 0;
		end else begin
			// retire the response first: it never belongs to a request taken this edge
			if (rsp_valid && !rsp_stall)
				check_status();
			if (req_valid && !req_stall)
				predict_status(cmpt_pkg::mode_t'(mode), channel, delay_ticks);
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == cmpt_pkg::REG_DIVIDER)
					div_reg = pwdata[cmpt_pkg::DIV_W-1:0];
				else
					period_reg = pwdata[cmpt_pkg::CNT_W-1:0];
			end
			fail_count      <= mismatches;
			pending         <= expected_status.size();
			checked         <= n_checked;
			wakes_seen      <= n_wakes;
			wraps_predicted <= int'(wraps);
		end
	end

endmodule

FILE: test/compare_timer_with_ms_tick_test.sv
// Top-level testbench for compare_timer_with_ms_tick: drives requests, register
// writes and response stalls; cmpt_status_checker predicts and compares.
// Depends on cmpt_pkg, cmpt_status_checker and the DUT.
module compare_timer_with_ms_tick_test;

	// generous upper bound for the whole run
	localparam int CYCLE_LIMIT = 4_000_000;

	logic                          clk;
	logic                          arst_n;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [cmpt_pkg::ADDR_W-1:0]   paddr;
	logic [cmpt_pkg::DATA_W-1:0]   pwdata;
	logic [cmpt_pkg::DATA_W-1:0]   prdata;
	logic                          pready;
	logic                          req_valid;
	logic                          req_stall;
	logic [1:0]                    mode;
	logic [cmpt_pkg::CH_W-1:0]     channel;
	logic [cmpt_pkg::CNT_W-1:0]    delay_ticks;
	logic                          rsp_valid;
	logic                          rsp_stall;
	logic [cmpt_pkg::FLAG_W-1:0]   event_flags;
	logic [cmpt_pkg::MS_W-1:0]     millisecond_count;
	logic [cmpt_pkg::CNT_W-1:0]    overflow_count;
	logic [cmpt_pkg::CNT_W-1:0]    counter_value;
	logic                          wake;

	int fail_count;
	int pending;
	int checked;
	int wakes_seen;
	int wraps_predicted;

	int requests_sent;
	int settings_used;
	int burst_left;

	compare_timer_with_ms_tick i_dut (.*);

	cmpt_status_checker i_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.pready            (pready),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.req_valid         (req_valid),
		.req_stall         (req_stall),
		.mode              (mode),
		.channel           (channel),
		.delay_ticks       (delay_ticks),
		.rsp_valid         (rsp_valid),
		.rsp_stall         (rsp_stall),
		.event_flags       (event_flags),
		.millisecond_count (millisecond_count),
		.overflow_count    (overflow_count),
		.counter_value     (counter_value),
		.wake              (wake),
		.fail_count        (fail_count),
		.pending           (pending),
		.checked           (checked),
		.wakes_seen        (wakes_seen),
		.wraps_predicted   (wraps_predicted)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard stop in case the DUT hangs on a handshake or loses responses.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("cycle limit of %0d reached, %0d responses still outstanding",
			CYCLE_LIMIT, pending);
		$display("compare_timer_with_ms_tick_test NOT OK");
		$finish;
	end

	// Response stalls. Cycles through a few styles: free flow, random
	// stalls, a sparse periodic stall and occasional long holds, so that
	// backpressure lands on every phase of the DUT pipeline.
	initial begin
		int style;
		int run_len;
		int period;
		rsp_stall <= 1'b0;
		forever begin
			style = $urandom_range(0, 3);
			run_len = $urandom_range(20, 200);
			period = $urandom_range(2, 7);
			case (style)
				0: begin
					repeat (run_len) begin
						@(posedge clk);
						rsp_stall <= 1'b0;
					end
				end
				1: begin
					repeat (run_len) begin
						@(posedge clk);
						rsp_stall <= ($urandom_range(0, 1) == 1);
					end
				end
				2: begin
					for (int i = 0; i < run_len; i++) begin
						@(posedge clk);
						rsp_stall <= (i % period == 0);
					end
				end
				default: begin
					repeat ($urandom_range(1, 8)) begin
						@(posedge clk);
						rsp_stall <= 1'b1;
					end
				end
			endcase
		end
	end

	// APB write: setup cycle, then access cycle until pready. The task then
	// idles with psel low, so back-to-back writes never re-raise psel in one step.
	task automatic write_reg(input logic reg_sel, input logic [cmpt_pkg::DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_sel, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Present one request and hold it until the DUT takes it. Requests go out
	// in bursts; at the end of a burst valid drops for a random gap.
	task automatic send_request(input cmpt_pkg::mode_t m,
			input logic [cmpt_pkg::CH_W-1:0] ch, input logic [cmpt_pkg::CNT_W-1:0] d);
		mode        <= m;
		channel     <= ch;
		delay_ticks <= d;
		req_valid   <= 1'b1;
		do @(posedge clk); while (req_stall);
		requests_sent++;
		if (burst_left == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			// mostly short bursts, now and then a long stretch with no gaps
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 300)
				: $urandom_range(1, 16);
		end else begin
			burst_left--;
		end
	endtask

	// Drop valid if a burst is still open.
	task automatic end_burst();
		if (req_valid) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Wait until every request has its response.
	task automatic drain();
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	// One random request. tick_pct sets the share of source ticks; arms
	// mostly use short delays so matches actually happen, sometimes any delay,
	// and now and then an out-of-range channel. Unused fields stay random.
	task automatic random_request(input int tick_pct);
		cmpt_pkg::mode_t            m;
		logic [cmpt_pkg::CH_W-1:0]  ch;
		logic [cmpt_pkg::CNT_W-1:0] d;
		int                         pick;
		if ($urandom_range(0, 99) < tick_pct) begin
			m = cmpt_pkg::MODE_TICK;
		end else begin
			pick = $urandom_range(0, 9);
			m = (pick < 6) ? cmpt_pkg::MODE_ARM :
				(pick < 8) ? cmpt_pkg::MODE_CLEAR : cmpt_pkg::MODE_READ;
		end
		if ($urandom_range(0, 9) == 0)
			ch = cmpt_pkg::CH_W'($urandom_range(0, 7));
		else
			ch = cmpt_pkg::CH_W'($urandom_range(1, cmpt_pkg::NUM_CH));
		case ($urandom_range(0, 4))
			0, 1, 2: d = cmpt_pkg::CNT_W'($urandom_range(0, 24));
			3:       d = cmpt_pkg::CNT_W'($urandom_range(0, 400));
			default: d = cmpt_pkg::CNT_W'($urandom);
		endcase
		send_request(m, ch, d);
	endtask

	// Reprogram both registers with the DUT idle, then send a random stream.
	task automatic run_phase(input logic [cmpt_pkg::DIV_W-1:0] div,
			input logic [cmpt_pkg::CNT_W-1:0] period, input int count, input int tick_pct);
		drain();
		write_reg(cmpt_pkg::REG_DIVIDER, cmpt_pkg::DATA_W'(div));
		write_reg(cmpt_pkg::REG_PERIOD, cmpt_pkg::DATA_W'(period));
		settings_used++;
		repeat (count) random_request(tick_pct);
		end_burst();
	endtask

	initial begin
		arst_n      <= 1'b0;
		psel        <= 1'b0;
		penable     <= 1'b0;
		pwrite      <= 1'b0;
		paddr       <= '0;
		pwdata      <= '0;
		req_valid   <= 1'b0;
		mode        <= cmpt_pkg::MODE_READ;
		channel     <= '0;
		delay_ticks <= '0;
		requests_sent = 0;
		settings_used = 1;
		burst_left    = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed, reset settings (divide by 64): status read, flag clear with
		// junk fields, arms of channel 0 and channels past the last one (no-ops),
		// ticks that only move the prescaler, channel 4 armed at the far end.
		send_request(cmpt_pkg::MODE_READ, 3'd0, 16'h0000);
		send_request(cmpt_pkg::MODE_CLEAR, 3'd7, 16'hFFFF);
		send_request(cmpt_pkg::MODE_ARM, 3'd0, 16'd5);
		send_request(cmpt_pkg::MODE_ARM, 3'd5, 16'd1);
		send_request(cmpt_pkg::MODE_ARM, 3'd7, 16'hFFFF);
		send_request(cmpt_pkg::MODE_TICK, 3'd7, 16'hFFFF);
		send_request(cmpt_pkg::MODE_TICK, 3'd0, 16'h0000);
		send_request(cmpt_pkg::MODE_ARM, 3'd4, 16'hFFFF);
		end_burst();

		// Directed, divide by one and period one: every channel fires within
		// four counts, channel 3 on every count; re-arming channel 4 drops its
		// flag; a zero delay on channel 1 waits for a full wrap.
		drain();
		write_reg(cmpt_pkg::REG_DIVIDER, 32'd1);
		write_reg(cmpt_pkg::REG_PERIOD, 32'd1);
		settings_used++;
		send_request(cmpt_pkg::MODE_ARM, 3'd1, 16'd1);
		send_request(cmpt_pkg::MODE_ARM, 3'd2, 16'd2);
		send_request(cmpt_pkg::MODE_ARM, 3'd3, 16'd1);
		send_request(cmpt_pkg::MODE_ARM, 3'd4, 16'd3);
		repeat (4) send_request(cmpt_pkg::MODE_TICK, 3'd0, 16'd0);
		send_request(cmpt_pkg::MODE_ARM, 3'd4, 16'd0);
		send_request(cmpt_pkg::MODE_READ, 3'd6, 16'h5A5A);
		send_request(cmpt_pkg::MODE_CLEAR, 3'd1, 16'hA5A5);
		send_request(cmpt_pkg::MODE_ARM, 3'd1, 16'd0);
		send_request(cmpt_pkg::MODE_TICK, 3'd2, 16'h8001);
		end_burst();

		// Random phases over a spread of settings: divider zero and above the
		// maximum, period zero and all-ones, plus one fully random setting.
		run_phase(7'd1, 16'd1, 250, 70);
		run_phase(7'd0, 16'd0, 250, 75);
		run_phase(7'd2, 16'd7, 250, 70);
		run_phase(7'd127, 16'hFFFF, 200, 80);
		run_phase(7'd64, 16'd3, 200, 80);
		run_phase(7'($urandom_range(0, 127)), 16'($urandom), 250, 70);
		run_phase(7'd3, 16'd5, 250, 70);
		run_phase(7'd5, 16'd0, 150, 70);

		drain();
		repeat (8) @(posedge clk);
		$display("%0d requests over %0d register settings; %0d responses checked",
			requests_sent, settings_used, checked);
		$display("%0d responses with wake, %0d counter wraps, %0d mismatches",
			wakes_seen, wraps_predicted, fail_count);
		if (fail_count == 0 && pending == 0)
			$display("compare_timer_with_ms_tick_test OK");
		else
			$display("compare_timer_with_ms_tick_test NOT OK");
		$finish;
	end

endmodule

FILE: files.f
rtl/core/cmpt_pkg.sv
rtl/core/cmpt_cfg.sv
rtl/core/cmpt_core.sv
rtl/core/compare_timer_with_ms_tick.sv
test/cmpt_status_checker.sv
test/compare_timer_with_ms_tick_test.sv
